[sv/tdl_pkg.sv]
`timescale 1ns / 1ps
package tdl_pkg;
   localparam int MaxEntriesDefault = 1024;
   localparam int MaxVarintBytes = 10;

   typedef enum logic [2:0] {
      ST_HIT = 3'd0, ST_LEAF = 3'd1, ST_MISS = 3'd2, ST_NODIR = 3'd3,
      ST_LOADED = 3'd4, ST_TOOMANY = 3'd5, ST_TRUNC = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0, PH_IDS = 3'd1, PH_RUNS = 3'd2, PH_LENS = 3'd3,
      PH_OFFS = 3'd4, PH_DONE = 3'd5, PH_DISCARD = 3'd6
   } phase_type;

   // controller -> datapath
   typedef struct packed {
      logic load_byte;    // take a directory byte (parser step)
      logic hil_init;     // latch query, start Hilbert walk
      logic hil_step;     // one Hilbert bit
      logic srch_init;    // start binary search
      logic srch_read;    // issue store read at mid
      logic srch_cmp;     // compare with read data
      logic fin_read;     // read entry at pick
      logic emit_query;   // drive query result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hil_done;
      logic srch_done;
   } stat_type;
endpackage

[sv/tdl_ctrl.sv]
`timescale 1ns / 1ps
module tdl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_command,
   input  tdl_pkg::stat_type stat,
   output tdl_pkg::cmd_type  cmd,
   output logic              busy
);
   import tdl_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_HIL   = 7'b0000010,
      S_SINIT = 7'b0000100,
      S_SREAD = 7'b0001000,
      S_SCMP  = 7'b0010000,
      S_FREAD = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_command) begin
                  cmd.hil_init = 1'b1;
                  state_in = S_HIL;
               end else begin
                  cmd.load_byte = 1'b1;
               end
            end
         end
         S_HIL: begin
            cmd.hil_step = 1'b1;
            if (stat.hil_done) state_in = S_SINIT;
         end
         S_SINIT: begin
            cmd.srch_init = 1'b1;
            state_in = S_SREAD;
         end
         S_SREAD: begin
            if (stat.srch_done) begin
               cmd.fin_read = 1'b1;
               state_in = S_FREAD;
            end else begin
               cmd.srch_read = 1'b1;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.srch_cmp = 1'b1;
            state_in = S_SREAD;
         end
         S_FREAD: state_in = S_EMIT;
         S_EMIT: begin
            cmd.emit_query = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

[sv/tdl_dp.sv]
`timescale 1ns / 1ps
module tdl_dp #(
   parameter int MaxEntries = tdl_pkg::MaxEntriesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  tdl_pkg::cmd_type  cmd,
   output tdl_pkg::stat_type stat,
   input  logic [7:0]        req_dir_byte,
   input  logic              req_final_byte,
   input  logic [4:0]        req_zoom,
   input  logic [30:0]       req_tile_x,
   input  logic [30:0]       req_tile_y,
   input  logic [63:0]       leaf_base,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [63:0]       rsp_found_offset,
   output logic [31:0]       rsp_found_length,
   output logic [63:0]       rsp_query_id,
   output logic [10:0]       rsp_entries_loaded
);
   import tdl_pkg::*;

   localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CW = $clog2(MaxEntries + 1);
   localparam int SW = AW + 2;   // signed search bounds

   logic [63:0] id_mem  [MaxEntries];
   logic [31:0] run_mem [MaxEntries];
   logic [31:0] len_mem [MaxEntries];
   logic [63:0] off_mem [MaxEntries];

   // parser state
   phase_type   phase_ff, phase_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic        valid_ff, valid_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  vbytes_ff, vbytes_in;
   logic [63:0] run_id_ff, run_id_in;
   logic [63:0] prev_end_ff, prev_end_in;
   logic [31:0] last_len_ff;  // length at the next fill slot, registered read

   // result register
   logic        r_valid_in;
   logic [2:0]  r_status_in;
   logic [63:0] r_off_in, r_qid_in;
   logic [31:0] r_len_in;
   logic [10:0] r_ent_in;

   // parser combinational
   logic [63:0] acc_new, v;
   logic [AW-1:0] f, nf;
   logic        cont, we_id, we_run, we_len, we_off;
   logic [63:0] off_val;
   logic [6:0]  shamt;
   logic        p_valid;
   logic [2:0]  p_status;

   always_comb begin
      phase_in = phase_ff; total_in = total_ff; fill_in = fill_ff;
      valid_in = valid_ff; acc_in = acc_ff; vbytes_in = vbytes_ff;
      run_id_in = run_id_ff; prev_end_in = prev_end_ff;
      p_valid = 1'b0; p_status = ST_HIT;
      we_id = 1'b0; we_run = 1'b0; we_len = 1'b0; we_off = 1'b0;
      shamt = 7'(vbytes_ff) * 7'd7;
      acc_new = acc_ff | (shamt < 7'd64 ? (64'(req_dir_byte[6:0]) << shamt) : 64'd0);
      v = acc_new;
      cont = req_dir_byte[7] && (vbytes_ff + 4'd1 < 4'(MaxVarintBytes));
      f = (fill_ff >= CW'(MaxEntries)) ? AW'(MaxEntries - 1) : fill_ff[AW-1:0];
      off_val = (fill_ff != '0 && v == 64'd0) ? prev_end_ff : v - 64'd1;
      if (cmd.load_byte) begin
         if (phase_ff == PH_COUNT && vbytes_ff == 4'd0) begin
            valid_in = 1'b0; total_in = '0; fill_in = '0;
            run_id_in = '0; prev_end_in = '0;
         end
         if (phase_ff == PH_DONE || phase_ff == PH_DISCARD) begin
            if (req_final_byte) begin
               phase_in = PH_COUNT;
               if (phase_ff == PH_DONE) begin
                  valid_in = 1'b1; p_valid = 1'b1; p_status = ST_LOADED;
               end
            end
         end else if (cont) begin
            acc_in = acc_new; vbytes_in = vbytes_ff + 4'd1;
            if (req_final_byte) begin
               valid_in = 1'b0; total_in = '0; fill_in = '0; acc_in = '0;
               vbytes_in = '0; phase_in = PH_COUNT;
               p_valid = 1'b1; p_status = ST_TRUNC;
            end
         end else begin
            acc_in = '0; vbytes_in = '0;
            if (phase_ff == PH_COUNT) begin
               if (v > 64'(MaxEntries)) begin
                  valid_in = 1'b0; total_in = '0; fill_in = '0;
                  phase_in = req_final_byte ? PH_COUNT : PH_DISCARD;
                  p_valid = 1'b1; p_status = ST_TOOMANY;
               end else begin
                  total_in = CW'(v); fill_in = '0;
                  phase_in = (v != 64'd0) ? PH_IDS : PH_DONE;
               end
            end else begin
               unique case (phase_ff)
                  PH_IDS: begin
                     run_id_in = run_id_ff + v; we_id = 1'b1;
                  end
                  PH_RUNS: we_run = 1'b1;
                  PH_LENS: we_len = 1'b1;
                  default: begin
                     we_off = 1'b1;
                     prev_end_in = off_val + 64'(last_len_ff);
                  end
               endcase
               if (fill_ff + CW'(1) >= total_ff) begin
                  fill_in = '0; phase_in = phase_type'(phase_ff + 3'd1);
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
            end
            if (req_final_byte && !p_valid) begin
               p_valid = 1'b1;
               if (phase_in == PH_DONE) begin
                  phase_in = PH_COUNT; valid_in = 1'b1; p_status = ST_LOADED;
               end else begin
                  valid_in = 1'b0; total_in = '0; fill_in = '0;
                  phase_in = PH_COUNT; p_status = ST_TRUNC;
               end
            end else if (req_final_byte) begin
               phase_in = PH_COUNT;
            end
         end
      end
   end

   // slot the parser works on next; its length is read ahead of the offsets
   assign nf = (fill_in >= CW'(MaxEntries)) ? AW'(MaxEntries - 1) : fill_in[AW-1:0];

   // Hilbert walk: one bit per cycle, msb first
   logic [30:0] hx_ff, hy_ff, hx_in, hy_in, nmask_ff;
   logic [4:0]  hz_ff, hcnt_ff;
   logic [63:0] hd_ff, hacc_ff;
   logic [30:0] sbit;
   logic        rx, ry;
   logic [63:0] ss;

   always_comb begin
      sbit = 31'd1 << (hcnt_ff - 5'd1);
      rx = |(hx_ff & sbit);
      ry = |(hy_ff & sbit);
      ss = 64'(sbit) << (hcnt_ff - 5'd1);
      hx_in = hx_ff; hy_in = hy_ff;
      if (!ry) begin
         if (rx) begin
            hx_in = nmask_ff - hx_ff; hy_in = nmask_ff - hy_ff;
         end
         {hx_in, hy_in} = {hy_in, hx_in};
      end
   end

   logic [30:0] qmask;
   assign qmask = (31'd1 << req_zoom) - 31'd1;
   // only looked at while stepping, so the last step counts as done
   assign stat.hil_done = (hcnt_ff <= 5'd1);

   always_ff @(posedge clock) begin
      if (cmd.hil_init) begin
         hx_ff <= req_tile_x & qmask; hy_ff <= req_tile_y & qmask;
         nmask_ff <= qmask; hz_ff <= req_zoom; hcnt_ff <= req_zoom;
         hd_ff <= '0; hacc_ff <= '0;
      end else if (cmd.hil_step && hcnt_ff != 5'd0) begin
         hx_ff <= hx_in; hy_ff <= hy_in;
         // quadrant digit (3*rx)^ry: high bit rx, low bit rx^ry
         hd_ff <= hd_ff + (rx ? {ss[62:0], 1'b0} : 64'd0) + ((rx ^ ry) ? ss : 64'd0);
         hacc_ff <= hacc_ff + ss;
         hcnt_ff <= hcnt_ff - 5'd1;
      end
   end
   // hacc sums 4^i over i<zoom, matching the base id of the level
   logic [63:0] qid;
   assign qid = hacc_ff + hd_ff;

   // binary search
   logic signed [SW-1:0] lo_ff, hi_ff, mid_ff;
   logic        pick_ok_ff, found_ff;
   logic [AW-1:0] rd_addr;
   logic [63:0] rd_id, rd_off;
   logic [31:0] rd_run, rd_len;
   logic [SW-1:0] mid_c;

   assign mid_c = SW'(lo_ff + ((hi_ff - lo_ff) >>> 1));
   assign stat.srch_done = found_ff || (lo_ff > hi_ff);

   always_comb begin
      rd_addr = mid_c[AW-1:0];
      if (cmd.fin_read) rd_addr = found_ff ? mid_ff[AW-1:0] : hi_ff[AW-1:0];
      if (cmd.load_byte) rd_addr = f;
   end

   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         lo_ff <= '0;
         hi_ff <= valid_ff ? SW'(total_ff) - SW'(1) : SW'(-1);
         found_ff <= 1'b0;
      end else if (cmd.srch_read) begin
         mid_ff <= mid_c;
      end else if (cmd.srch_cmp) begin
         if (qid > rd_id) lo_ff <= mid_ff + SW'(1);
         else if (qid < rd_id) hi_ff <= mid_ff - SW'(1);
         else found_ff <= 1'b1;
      end
      if (cmd.fin_read) pick_ok_ff <= found_ff || (hi_ff >= 0);
   end

   always_ff @(posedge clock) begin
      if (we_id)  id_mem[f]  <= run_id_in;
      if (we_run) run_mem[f] <= v[31:0];
      if (we_len) len_mem[f] <= v[31:0];
      if (we_off) off_mem[f] <= off_val;
      rd_id <= id_mem[rd_addr];
      rd_run <= run_mem[rd_addr];
      rd_len <= len_mem[rd_addr];
      rd_off <= off_mem[rd_addr];
   end

   // a length written this cycle to the next slot is passed straight on
   always_ff @(posedge clock) begin
      if (we_len && f == nf) last_len_ff <= v[31:0];
      else                   last_len_ff <= len_mem[nf];
   end

   // query result
   logic        hit_pick;
   logic [63:0] qdiff;
   assign qdiff = qid - rd_id;
   always_comb begin
      r_valid_in = p_valid; r_status_in = p_status;
      hit_pick = pick_ok_ff && (found_ff || rd_run == 32'd0 || qdiff < 64'(rd_run));
      r_off_in = '0; r_len_in = '0; r_qid_in = '0;
      r_ent_in = valid_in ? 11'(total_in) : 11'd0;
      if (cmd.emit_query) begin
         r_valid_in = 1'b1; r_qid_in = qid;
         r_ent_in = valid_ff ? 11'(total_ff) : 11'd0;
         if (!valid_ff) r_status_in = ST_NODIR;
         else if (!hit_pick) r_status_in = ST_MISS;
         else if (rd_run != 32'd0) begin
            r_status_in = ST_HIT; r_off_in = rd_off; r_len_in = rd_len;
         end else begin
            r_status_in = ST_LEAF; r_off_in = leaf_base + rd_off; r_len_in = rd_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT; total_ff <= '0; fill_ff <= '0; valid_ff <= 1'b0;
         acc_ff <= '0; vbytes_ff <= '0; run_id_ff <= '0; prev_end_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         phase_ff <= phase_in; total_ff <= total_in; fill_ff <= fill_in;
         valid_ff <= valid_in; acc_ff <= acc_in; vbytes_ff <= vbytes_in;
         run_id_ff <= run_id_in; prev_end_ff <= prev_end_in;
         rsp_valid <= r_valid_in;
      end
      rsp_status <= r_status_in; rsp_found_offset <= r_off_in;
      rsp_found_length <= r_len_in; rsp_query_id <= r_qid_in;
      rsp_entries_loaded <= r_ent_in;
   end

   logic unused_z;
   assign unused_z = ^hz_ff;
endmodule

[sv/tile_directory_load_and_lookup.sv]
`timescale 1ns / 1ps
// Directory byte: taken while idle, result (if any) in the cycle after; a byte a cycle while
// not busy. Query: busy through the Hilbert walk, search init, probes <= log2(entries)+1
//   (11 at 1024 entries) of a read and a compare each, final read and emit; the result
//   beat comes in the cycle busy drops. The walk takes one bit a cycle; one store read port.
// Reset: synchronous; clears parser state, no directory, leaf base 0.
// Results are a one-cycle strobe; the receiver cannot stall.
module tile_directory_load_and_lookup #(
   parameter int MaxEntries = tdl_pkg::MaxEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_dir_byte,
   input  logic        req_final_byte,
   input  logic [4:0]  req_zoom,
   input  logic [30:0] req_tile_x,
   input  logic [30:0] req_tile_y,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_found_offset,
   output logic [31:0] rsp_found_length,
   output logic [63:0] rsp_query_id,
   output logic [10:0] rsp_entries_loaded,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import tdl_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [63:0] leaf_base_ff;

   // single CSR: leaf area base at address 0
   assign pready = 1'b1;
   assign prdata = (paddr == 1'b0) ? leaf_base_ff : 64'd0;
   always_ff @(posedge clock) begin
      if (reset) leaf_base_ff <= '0;
      else if (psel && penable && pwrite && paddr == 1'b0) leaf_base_ff <= pwdata;
   end

   tdl_ctrl u_ctrl (
      .clock, .reset, .start, .req_command, .stat, .cmd, .busy
   );

   tdl_dp #(.MaxEntries(MaxEntries)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_dir_byte, .req_final_byte, .req_zoom, .req_tile_x, .req_tile_y,
      .leaf_base(leaf_base_ff),
      .rsp_valid, .rsp_status, .rsp_found_offset, .rsp_found_length,
      .rsp_query_id, .rsp_entries_loaded
   );
endmodule

[sv/tdl_checker.sv]
`timescale 1ns / 1ps
module tdl_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_command,
   input logic       rsp_valid,
   input logic [2:0] rsp_status
);
   import tdl_pkg::*;

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command |=> busy) else $error("query not busy");
   a_byte_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_command |=> !busy) else $error("byte stalled");
   a_status_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 3'd7) else $error("bad status");
   a_q_result: assert property (@(posedge clock) disable iff (reset)
      busy && !$past(busy) |-> !rsp_valid) else $error("early result");
endmodule

bind tile_directory_load_and_lookup tdl_checker u_chk (
   .clock, .reset, .start, .busy, .req_command, .rsp_valid, .rsp_status
);

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import tdl_pkg::*;

   // one expected result beat
   typedef struct {
      status_type  st;
      bit [63:0]   off;
      bit [31:0]   len;
      bit [63:0]   qid;
      bit [10:0]   ent;
   } dir_rsp_type;

   // Predictor of the directory loader / lookup plus the queue of pending results.
   class scoreboard_type;
      bit [63:0]   leaf_base;
      bit [63:0]   id_mem [1024];
      bit [31:0]   run_mem [1024];
      bit [31:0]   len_mem [1024];
      bit [63:0]   off_mem [1024];
      int unsigned total, fill, nbytes;
      bit          valid;
      phase_type   ph;
      bit [63:0]   accum, run_id, prev_end;
      dir_rsp_type pending [$];
      int          errors;

      function new();
         leaf_base = 0; total = 0; fill = 0; nbytes = 0; valid = 0;
         ph = PH_COUNT; accum = 0; run_id = 0; prev_end = 0; errors = 0;
      endfunction

      function bit [63:0] tile_id(int unsigned z, bit [31:0] x, bit [31:0] y);
         bit [63:0] acc, d;
         bit [31:0] n, s, t, rx, ry;
         acc = 0; d = 0;
         n = 32'd1 << z;
         for (int i = 0; i < z; i++) acc += 64'd1 << (2 * i);
         for (s = n / 2; s > 0; s = s / 2) begin
            rx = (x & s) ? 1 : 0;
            ry = (y & s) ? 1 : 0;
            d += 64'(s) * 64'(s) * 64'((3 * rx) ^ ry);
            if (ry == 0) begin
               if (rx == 1) begin
                  x = n - 1 - x;
                  y = n - 1 - y;
               end
               t = x; x = y; y = t;
            end
         end
         return acc + d;
      endfunction

      function void post(status_type st, bit [63:0] off, bit [31:0] len, bit [63:0] qid);
         dir_rsp_type r;
         r.st = st; r.off = off; r.len = len; r.qid = qid;
         r.ent = valid ? total[10:0] : 11'd0;
         pending.push_back(r);
      endfunction

      function void drop_load();
         valid = 0; total = 0; fill = 0; accum = 0; nbytes = 0;
      endfunction

      function void advance();
         fill++;
         if (fill >= total) begin
            fill = 0;
            ph = phase_type'(ph + 1);
         end
      endfunction

      function void lookup(bit [4:0] z, bit [30:0] x, bit [30:0] y);
         bit [31:0] mask;
         bit [63:0] qid;
         int lo, hi, pick, k;
         mask = (z == 0) ? 32'd0 : ((32'd1 << z) - 1);
         qid = tile_id(32'(z), {1'b0, x} & mask, {1'b0, y} & mask);
         if (!valid) begin
            post(ST_NODIR, 0, 0, qid);
            return;
         end
         lo = 0; hi = int'(total) - 1; pick = -1;
         if (hi >= 1024) hi = 1023;
         while (lo <= hi) begin
            k = lo + (hi - lo) / 2;
            if (qid > id_mem[k]) lo = k + 1;
            else if (qid < id_mem[k]) hi = k - 1;
            else begin
               pick = k;
               break;
            end
         end
         if (pick < 0 && hi >= 0)
            if (run_mem[hi] == 0 || qid - id_mem[hi] < 64'(run_mem[hi])) pick = hi;
         if (pick < 0) post(ST_MISS, 0, 0, qid);
         else if (run_mem[pick] > 0) post(ST_HIT, off_mem[pick], len_mem[pick], qid);
         else post(ST_LEAF, leaf_base + off_mem[pick], len_mem[pick], qid);
      endfunction

      function void take_byte(bit [7:0] b, bit fin);
         bit [63:0] v, o;
         int unsigned f;
         if (ph == PH_COUNT && nbytes == 0) begin
            drop_load();
            run_id = 0; prev_end = 0;
         end
         if (ph == PH_DONE || ph == PH_DISCARD) begin
            if (!fin) return;
            if (ph == PH_DISCARD) begin
               ph = PH_COUNT;
               return;
            end
            ph = PH_COUNT; valid = 1;
            post(ST_LOADED, 0, 0, 0);
            return;
         end
         accum |= 64'(b & 8'h7f) << (7 * nbytes);
         nbytes++;
         if (b[7] && nbytes < 10) begin
            if (!fin) return;
            drop_load(); ph = PH_COUNT;
            post(ST_TRUNC, 0, 0, 0);
            return;
         end
         v = accum; accum = 0; nbytes = 0;
         f = (fill >= 1024) ? 1023 : fill;
         case (ph)
            PH_COUNT: begin
               if (v > 64'd1024) begin
                  drop_load();
                  ph = fin ? PH_COUNT : PH_DISCARD;
                  post(ST_TOOMANY, 0, 0, 0);
                  return;
               end
               total = v[31:0]; fill = 0;
               ph = (v != 0) ? PH_IDS : PH_DONE;
            end
            PH_IDS: begin
               run_id += v; id_mem[f] = run_id; advance();
            end
            PH_RUNS: begin
               run_mem[f] = v[31:0]; advance();
            end
            PH_LENS: begin
               len_mem[f] = v[31:0]; advance();
            end
            default: begin
               o = (f > 0 && v == 0) ? prev_end : v - 1;
               off_mem[f] = o;
               prev_end = o + 64'(len_mem[f]);
               advance();
            end
         endcase
         if (!fin) return;
         if (ph == PH_DONE) begin
            ph = PH_COUNT; valid = 1;
            post(ST_LOADED, 0, 0, 0);
            return;
         end
         drop_load(); ph = PH_COUNT;
         post(ST_TRUNC, 0, 0, 0);
      endfunction

      function void note(bit cmd, bit [7:0] b, bit fin, bit [4:0] z, bit [30:0] x,
                         bit [30:0] y);
         if (cmd) lookup(z, x, y);
         else take_byte(b, fin);
      endfunction

      function void check(bit [2:0] st, bit [63:0] off, bit [31:0] len, bit [63:0] qid,
                          bit [10:0] ent);
         dir_rsp_type e;
         if (pending.size() == 0) begin
            $error("result beat with nothing expected, status %0d", st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st != e.st) begin
            $error("status: expected %0d, got %0d", e.st, st); errors++;
         end
         if (off != e.off) begin
            $error("found_offset: expected %h, got %h", e.off, off); errors++;
         end
         if (len != e.len) begin
            $error("found_length: expected %h, got %h", e.len, len); errors++;
         end
         if (qid != e.qid) begin
            $error("query_id: expected %h, got %h", e.qid, qid); errors++;
         end
         if (ent != e.ent) begin
            $error("entries_loaded: expected %0d, got %0d", e.ent, ent); errors++;
         end
      endfunction
   endclass

   localparam int StallLimit = 20000;   // idle cycles before the watchdog trips
   localparam int SettleCycles = 100;   // longer than the worst query latency

   logic        clock, reset, start, busy;
   logic        req_command, req_final_byte;
   logic [7:0]  req_dir_byte;
   logic [4:0]  req_zoom;
   logic [30:0] req_tile_x, req_tile_y;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_found_offset, rsp_query_id;
   logic [31:0] rsp_found_length;
   logic [10:0] rsp_entries_loaded;
   logic        psel, penable, pwrite, paddr, pready;
   logic [63:0] pwdata, prdata;

   scoreboard_type sb = new();
   int          idle_pct;       // sender gap probability, per phase
   int          sent;           // beats accepted so far
   int          stall_cnt;
   // tiles used to build the current directory, so queries can aim at them
   bit [4:0]    tile_z [1024];
   bit [30:0]   tile_x [1024], tile_y [1024];
   int          n_tiles;
   bit [7:0]    dir_q [$];

   tile_directory_load_and_lookup i_dut (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // result monitor: a strobe beat is taken at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check(rsp_status, rsp_found_offset, rsp_found_length, rsp_query_id,
                  rsp_entries_loaded);
   end

   // watchdog: counts edges where nothing at all moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // one beat on the request channel; called at a falling edge, returns at one,
   // leaving start high so a back-to-back beat needs no extra assignment
   task automatic send(bit cmd, bit [7:0] b, bit fin, bit [4:0] z, bit [30:0] x,
                       bit [30:0] y);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_dir_byte <= 8'($urandom);
         @(negedge clock);
      end
      start <= 1'b1;
      req_command <= cmd; req_dir_byte <= b; req_final_byte <= fin;
      req_zoom <= z; req_tile_x <= x; req_tile_y <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(cmd, b, fin, z, x, y);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_query(bit [4:0] z, bit [30:0] x, bit [30:0] y);
      send(1'b1, 8'($urandom), 1'($urandom), z, x, y);
   endtask

   // hold off until nothing is pending, then let a query in flight finish
   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_base(bit [63:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= 1'b0; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.leaf_base = val;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic void push_varint(bit [63:0] v, bit long_form);
      if (long_form) begin
         // ten bytes, continuation left set on the last one
         for (int i = 0; i < 9; i++) dir_q.push_back(8'h80 | {1'b0, v[7 * i +: 7]});
         dir_q.push_back(8'h80 | 8'($urandom));
         return;
      end
      while (v >= 64'h80) begin
         dir_q.push_back(8'h80 | {1'b0, v[6:0]});
         v = v >> 7;
      end
      dir_q.push_back(v[7:0]);
   endfunction

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // kind: 0 clean, 1 trailing bytes, 2 truncated, 3 too many entries
   function automatic void build_dir(int n, int kind, bit wild);
      bit [63:0] ids [$];
      bit [63:0] prev, v;
      bit [31:0] mask;
      int cut;
      dir_q.delete();
      if (kind == 3) begin
         push_varint(64'd1025 + $urandom_range(($urandom_range(3) == 0) ? 32'hffff : 40),
                     $urandom_range(3) == 0);
         repeat ($urandom_range(5)) dir_q.push_back(8'($urandom));
         return;
      end
      n_tiles = n;
      for (int i = 0; i < n; i++) begin
         tile_z[i] = 5'($urandom_range(8));
         mask = (32'd1 << tile_z[i]) - 1;
         tile_x[i] = 31'($urandom & mask);
         tile_y[i] = 31'($urandom & mask);
         ids.push_back(sb.tile_id(32'(tile_z[i]), {1'b0, tile_x[i]}, {1'b0, tile_y[i]}));
      end
      ids.sort();
      push_varint(64'(n), 1'b0);
      prev = 0;
      foreach (ids[i]) begin
         v = (wild && $urandom_range(9) == 0) ? rand64() : ids[i] - prev;
         prev = ids[i];
         push_varint(v, wild && $urandom_range(7) == 0);
      end
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1: v = 0;                          // leaf pointer
            2: v = wild ? rand64() : 64'($urandom);  // wide run, low 32 bits kept
            default: v = 64'($urandom_range(1, 4));
         endcase
         push_varint(v, 1'b0);
      end
      for (int i = 0; i < n; i++)
         push_varint($urandom_range(1) ? 64'($urandom_range(1, 5000))
                                       : (wild ? rand64() : 64'($urandom)), 1'b0);
      for (int i = 0; i < n; i++)
         push_varint($urandom_range(9) < 4 ? 64'd0 : rand64() >> $urandom_range(63),
                     wild && $urandom_range(7) == 0);
      if (kind == 1) repeat ($urandom_range(1, 4)) dir_q.push_back(8'($urandom));
      if (kind == 2 && dir_q.size() > 1) begin
         cut = $urandom_range(1, dir_q.size() - 1);
         while (dir_q.size() > cut) void'(dir_q.pop_back());
      end
   endfunction

   // stream the built directory; a stray query may land mid-load
   task automatic stream_dir(bit noise);
      foreach (dir_q[i]) begin
         if (noise && $urandom_range(49) == 0)
            send_query(5'($urandom), 31'($urandom), 31'($urandom));
         send(1'b0, dir_q[i], i == dir_q.size() - 1, 5'($urandom), 31'($urandom),
              31'($urandom));
      end
   endtask

   task automatic random_query();
      int k;
      bit [30:0] x, y;
      if (n_tiles > 0 && $urandom_range(9) < 6) begin
         k = $urandom_range(n_tiles - 1);
         x = tile_x[k]; y = tile_y[k];
         if ($urandom_range(3) == 0) x = x + 31'd1;
         // upper bits set: must be masked away by the block
         send_query(tile_z[k], x | (31'($urandom) & ~((31'd1 << tile_z[k]) - 31'd1)), y);
      end else begin
         send_query(5'($urandom), 31'($urandom), 31'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1; start = 1'b0;
      req_command = 1'b0; req_dir_byte = 8'h00; req_final_byte = 1'b0;
      req_zoom = 5'd0; req_tile_x = 31'd0; req_tile_y = 31'd0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 1'b0; pwdata = 64'd0;
      idle_pct = 0; sent = 0; n_tiles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      write_base(64'hffff_ffff_ffff_ffff);
      send_query(5'd0, 31'd0, 31'd0);                    // no directory yet
      send_query(5'd31, 31'h7fff_ffff, 31'h7fff_ffff);
      // empty directory, then a miss
      send(1'b0, 8'h00, 1'b1, 5'd0, 31'd0, 31'd0);
      send_query(5'd3, 31'd5, 31'd2);
      // two entries: first offset code 0, second a leaf continuing from the first
      dir_q = {8'h02, 8'h00, 8'h05, 8'h00, 8'h00, 8'h10, 8'h20, 8'h00, 8'h00};
      stream_dir(1'b0);
      send_query(5'd0, 31'd0, 31'd0);
      send_query(5'd1, 31'd1, 31'd0);
      send_query(5'd1, 31'd1, 31'd1);
      // long varint count: too many entries, then ignored bytes
      dir_q.delete();
      push_varint(64'hffff, 1'b1);
      dir_q.push_back(8'hff);
      stream_dir(1'b0);
      send_query(5'd0, 31'd0, 31'd0);
      // count with continuation bit on the final byte: truncated
      send(1'b0, 8'h81, 1'b1, 5'd0, 31'd0, 31'd0);
      // one entry plus trailing bytes
      dir_q = {8'h01, 8'h07, 8'h01, 8'h04, 8'h09, 8'hff, 8'h00};
      stream_dir(1'b0);
      send_query(5'd2, 31'd3, 31'd1);
      drain();
      write_base(64'd0);

      // --- random, four sender phases ---
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: idle_pct = 82;
            3: idle_pct = 37;
            default: idle_pct = 0;
         endcase
         while (sent < 30 + 390 * (phase + 1)) begin
            int kind, n;
            kind = $urandom_range(19);
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(12);
            build_dir(n, (kind < 12) ? 0 : (kind < 15) ? 1 : (kind < 17) ? 2 : 3,
                      $urandom_range(3) == 0);
            stream_dir(1'b1);
            repeat ($urandom_range(5, 20)) random_query();
         end
         drain();
         write_base(phase == 2 ? 64'hffff_ffff_ffff_ffff : rand64());
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

[filelist.f]
sv/tdl_pkg.sv
sv/tdl_ctrl.sv
sv/tdl_dp.sv
sv/tile_directory_load_and_lookup.sv
sv/tdl_checker.sv
tb/testbench.sv
